### hdl/sliding_window_average_xy_top_defines.svh
// ----------------------------------------------------------------------------
// Sliding window average assertion macros
// Concurrent check shorthands for the sliding window average block.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_AVERAGE_XY_TOP_DEFINES_SVH
`define SLIDING_WINDOW_AVERAGE_XY_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SWA_ASSERT_IMPLIES(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("swa check failed");
`define SWA_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("swa check failed");
`else
`define SWA_ASSERT_IMPLIES(lbl, pre, post)
`define SWA_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

### hdl/swa_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window average package
// Sizes, state codes and shared types for the sliding window average block.
// ----------------------------------------------------------------------------
package swa_pkg;

   localparam int WINDOW_MAX   = 64;
   localparam int SAMPLE_WIDTH = 32;
   localparam int SLOT_WIDTH   = $clog2(WINDOW_MAX);
   localparam int LEN_WIDTH    = 7;
   localparam int SUM_WIDTH    = SAMPLE_WIDTH + SLOT_WIDTH;
   localparam int STEP_WIDTH   = $clog2(SUM_WIDTH);
   localparam int LEN_RESET    = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

endpackage

### hdl/swa_if.sv
// ----------------------------------------------------------------------------
// Sliding window average channels
// Valid/ready channels for points, means and the window length register.
// ----------------------------------------------------------------------------
interface swa_req_if
   import swa_pkg::*;
;
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] x_value;
   logic signed [SAMPLE_WIDTH-1:0] y_value;
   logic                           first_point;

   modport source (output valid, x_value, y_value, first_point, input ready);
   modport sink   (input valid, x_value, y_value, first_point, output ready);
endinterface

interface swa_rsp_if
   import swa_pkg::*;
;
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] mean_x;
   logic signed [SAMPLE_WIDTH-1:0] mean_y;

   modport source (output valid, mean_x, mean_y, input ready);
   modport sink   (input valid, mean_x, mean_y, output ready);
endinterface

interface swa_csr_if
   import swa_pkg::*;
;
   logic                 valid;
   logic                 ready;
   logic [LEN_WIDTH-1:0] window_len;

   modport source (output valid, window_len, input ready);
   modport sink   (input valid, window_len, output ready);
endinterface

### hdl/swa_div.sv
// ----------------------------------------------------------------------------
// Sliding window average divider
// Restoring serial divider: signed window sum by window length, one quotient
// bit per cycle, result truncated toward zero.
// ----------------------------------------------------------------------------
module swa_div
   import swa_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [SUM_WIDTH-1:0]    dividend,
   input  logic        [LEN_WIDTH-1:0]    divisor,
   output logic                           done,
   output logic signed [SAMPLE_WIDTH-1:0] quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_WIDTH-1:0] step_ff, step_in;
   logic [SUM_WIDTH-1:0]  quo_ff, quo_in;
   logic [LEN_WIDTH-1:0]  rem_ff, rem_in;
   logic [LEN_WIDTH-1:0]  den_ff, den_in;
   logic                  neg_ff, neg_in;
   logic [LEN_WIDTH:0]    trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quo_ff[SUM_WIDTH-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         neg_in  = dividend[SUM_WIDTH-1];
         quo_in  = dividend[SUM_WIDTH-1] ? SUM_WIDTH'(-dividend) : SUM_WIDTH'(dividend);
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = LEN_WIDTH'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[SUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[LEN_WIDTH-1:0];
            quo_in = {quo_ff[SUM_WIDTH-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_WIDTH'(SUM_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -SAMPLE_WIDTH'(quo_ff) : SAMPLE_WIDTH'(quo_ff);

endmodule

### hdl/sliding_window_average_xy_top.sv
// ----------------------------------------------------------------------------
// Sliding window average, x/y
// Boxcar mean of a stream of signed Q16.16 points over the last window_len
// points (1 to 64; 0 acts as 1, larger values as 64). Points sit in a 64-entry
// ring memory next to two running sums; each point reads the outgoing point,
// updates the sums and writes itself back. Once the window is full each point
// yields one transfer of both means, truncated toward zero. first_point, or a
// write of window_len, restarts the fill. A point passes through ST_READ and
// ST_UPDATE; one that yields means then waits in ST_DIVIDE for the two 38-step
// serial dividers, one per sum, and in ST_DONE for the output register. A new
// point is taken only in ST_IDLE. A finished mean waits in an output register,
// so the next point is taken while it is still pending.
// ----------------------------------------------------------------------------
`include "sliding_window_average_xy_top_defines.svh"

module sliding_window_average_xy_top
   import swa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   swa_req_if.sink   req_ch,
   swa_rsp_if.source rsp_ch,
   swa_csr_if.sink   csr_ch
);

   state_type                      state_ff, state_in;
   logic [LEN_WIDTH-1:0]           window_len_ff, window_len_in;
   logic signed [SUM_WIDTH-1:0]    x_sum_ff, x_sum_in;
   logic signed [SUM_WIDTH-1:0]    y_sum_ff, y_sum_in;
   logic [LEN_WIDTH-1:0]           fill_count_ff, fill_count_in;
   logic [SLOT_WIDTH-1:0]          write_slot_ff, write_slot_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] x_val_ff, y_val_ff;
   logic signed [SAMPLE_WIDTH-1:0] mean_x_ff, mean_y_ff;
   logic [2*SAMPLE_WIDTH-1:0]      rd_data_ff;

   logic [2*SAMPLE_WIDTH-1:0]      win_mem [WINDOW_MAX];

   logic [LEN_WIDTH-1:0]           act_len;
   logic [SLOT_WIDTH:0]            slot_ext;
   logic [SLOT_WIDTH:0]            len_ext;
   logic [SLOT_WIDTH-1:0]          old_slot;
   logic                           full;
   logic                           produce;
   logic signed [SAMPLE_WIDTH-1:0] x_old, y_old;
   logic                           mem_rd, mem_wr;
   logic                           div_start;
   logic                           rsp_load;
   logic                           x_done, y_done;
   logic signed [SAMPLE_WIDTH-1:0] x_quo, y_quo;

   always_comb begin
      if (window_len_ff == '0) begin
         act_len = LEN_WIDTH'(1);
      end else if (window_len_ff > LEN_WIDTH'(WINDOW_MAX)) begin
         act_len = LEN_WIDTH'(WINDOW_MAX);
      end else begin
         act_len = window_len_ff;
      end
   end

   assign slot_ext = {1'b0, write_slot_ff};
   assign len_ext  = (SLOT_WIDTH + 1)'(act_len);
   assign old_slot = (slot_ext >= len_ext) ? SLOT_WIDTH'(slot_ext - len_ext)
                   : SLOT_WIDTH'(slot_ext + (SLOT_WIDTH + 1)'(WINDOW_MAX) - len_ext);

   assign full    = fill_count_ff >= act_len;
   assign produce = full || (LEN_WIDTH'(fill_count_ff + 1'b1) == act_len);
   assign x_old   = rd_data_ff[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
   assign y_old   = rd_data_ff[SAMPLE_WIDTH-1:0];

   always_comb begin
      state_in      = state_ff;
      window_len_in = window_len_ff;
      x_sum_in      = x_sum_ff;
      y_sum_in      = y_sum_ff;
      fill_count_in = fill_count_ff;
      write_slot_in = write_slot_ff;
      rsp_valid_in  = rsp_valid_ff;
      req_ch.ready  = 1'b0;
      csr_ch.ready  = 1'b0;
      mem_rd        = 1'b0;
      mem_wr        = 1'b0;
      div_start     = 1'b0;
      rsp_load      = 1'b0;

      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            csr_ch.ready = 1'b1;
            if (csr_ch.valid) begin
               window_len_in = csr_ch.window_len;
               x_sum_in      = '0;
               y_sum_in      = '0;
               fill_count_in = '0;
               write_slot_in = '0;
            end
            if (req_ch.valid) begin
               if (req_ch.first_point) begin
                  x_sum_in      = '0;
                  y_sum_in      = '0;
                  fill_count_in = '0;
                  write_slot_in = '0;
               end
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            mem_rd   = 1'b1;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            mem_wr   = 1'b1;
            x_sum_in = x_sum_ff - (full ? SUM_WIDTH'(x_old) : '0) + SUM_WIDTH'(x_val_ff);
            y_sum_in = y_sum_ff - (full ? SUM_WIDTH'(y_old) : '0) + SUM_WIDTH'(y_val_ff);
            write_slot_in = (write_slot_ff == SLOT_WIDTH'(WINDOW_MAX - 1)) ? '0
                          : write_slot_ff + 1'b1;
            if (!full) begin
               fill_count_in = fill_count_ff + 1'b1;
            end
            if (produce) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (x_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_len_ff <= LEN_WIDTH'(LEN_RESET);
         x_sum_ff      <= '0;
         y_sum_ff      <= '0;
         fill_count_ff <= '0;
         write_slot_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_len_ff <= window_len_in;
         x_sum_ff      <= x_sum_in;
         y_sum_ff      <= y_sum_in;
         fill_count_ff <= fill_count_in;
         write_slot_ff <= write_slot_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         x_val_ff <= req_ch.x_value;
         y_val_ff <= req_ch.y_value;
      end
      if (rsp_load) begin
         mean_x_ff <= x_quo;
         mean_y_ff <= y_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         rd_data_ff <= win_mem[old_slot];
      end
      if (mem_wr) begin
         win_mem[write_slot_ff] <= {x_val_ff, y_val_ff};
      end
   end

   swa_div u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (x_sum_in),
      .divisor  (act_len),
      .done     (x_done),
      .quotient (x_quo)
   );

   swa_div u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (y_sum_in),
      .divisor  (act_len),
      .done     (y_done),
      .quotient (y_quo)
   );

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.mean_x = mean_x_ff;
   assign rsp_ch.mean_y = mean_y_ff;

   `SWA_ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_count_ff <= act_len)
   `SWA_ASSERT_IMPLIES(a_div_lockstep, 1'b1, x_done == y_done)
   `SWA_ASSERT_IMPLIES(a_done_in_divide, x_done, state_ff == ST_DIVIDE)
   `SWA_ASSERT_IMPLIES(a_result_full, state_ff == ST_DONE, fill_count_ff == act_len)
   `SWA_ASSERT_NEXT(a_fill_only, state_ff == ST_UPDATE && !produce, state_ff == ST_IDLE)

endmodule

### tb/sv/swa_mean_checker.sv
// ----------------------------------------------------------------------------
// Sliding window average mean checker
// Watches the point, mean and window length channels of the sliding window
// average block. Every accepted point goes through a local boxcar model: ring
// store, wide running sums and fill count. Each mean that model produces is
// queued, and each mean transfer from the block is compared field by field
// with the oldest queued one. The mismatch count and the number of means
// still owed are passed to the testbench top.
// ----------------------------------------------------------------------------
module swa_mean_checker
   import swa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   swa_req_if   req_ch,
   swa_rsp_if   rsp_ch,
   swa_csr_if   csr_ch,
   output int   mismatch_count,
   output int   means_pending
);

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [SUM_WIDTH-1:0]    total_type;

   typedef struct packed {
      sample_type mean_x;
      sample_type mean_y;
   } mean_pair_type;

   sample_type           x_ring [WINDOW_MAX];
   sample_type           y_ring [WINDOW_MAX];
   total_type            x_total;
   total_type            y_total;
   logic [LEN_WIDTH-1:0] len_reg;
   int unsigned          points_held;
   int unsigned          next_slot;
   mean_pair_type        mean_queue [$];
   int                   errors = 0;

   function automatic int unsigned span(logic [LEN_WIDTH-1:0] raw);
      if (raw == 0) return 1;
      if (raw > WINDOW_MAX) return WINDOW_MAX;
      return 32'(raw);
   endfunction

   function automatic void restart_fill();
      x_total     = '0;
      y_total     = '0;
      points_held = 0;
      next_slot   = 0;
   endfunction

   function automatic void flag(string field, sample_type want, sample_type got);
      errors++;
      if (errors <= 10)
         $display("%0t: %s mismatch: expected %0d (0x%h), got %0d (0x%h)",
                  $realtime, field, want, want, got, got);
   endfunction

   function automatic void take_point(sample_type xv, sample_type yv, logic fp);
      int unsigned   n;
      int unsigned   old;
      total_type     divisor;
      mean_pair_type mean;
      n = span(len_reg);
      if (fp) restart_fill();
      // drop the oldest point from the sums once the window is full
      if (points_held >= n) begin
         old = (next_slot + WINDOW_MAX - n) % WINDOW_MAX;
         x_total -= x_ring[old];
         y_total -= y_ring[old];
      end
      x_ring[next_slot] = xv;
      y_ring[next_slot] = yv;
      x_total += xv;
      y_total += yv;
      next_slot = (next_slot + 1) % WINDOW_MAX;
      if (points_held < n) points_held++;
      if (points_held == n) begin
         divisor     = total_type'(n);
         mean.mean_x = sample_type'(x_total / divisor);
         mean.mean_y = sample_type'(y_total / divisor);
         mean_queue.push_back(mean);
      end
   endfunction

   function automatic void check_mean(sample_type got_x, sample_type got_y);
      mean_pair_type want;
      if (mean_queue.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("%0t: unexpected mean transfer x=%0d y=%0d", $realtime, got_x, got_y);
      end else begin
         want = mean_queue.pop_front();
         if (got_x !== want.mean_x) flag("mean_x", want.mean_x, got_x);
         if (got_y !== want.mean_y) flag("mean_y", want.mean_y, got_y);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         len_reg = LEN_WIDTH'(LEN_RESET);
         restart_fill();
         mean_queue.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            len_reg = csr_ch.window_len;
            restart_fill();
         end
         if (rsp_ch.valid && rsp_ch.ready)
            check_mean(rsp_ch.mean_x, rsp_ch.mean_y);
         if (req_ch.valid && req_ch.ready)
            take_point(req_ch.x_value, req_ch.y_value, req_ch.first_point);
      end
      mismatch_count <= errors;
      means_pending  <= mean_queue.size();
   end

endmodule

### tb/sv/sliding_window_average_xy_top_tb.sv
// ----------------------------------------------------------------------------
// Sliding window average testbench
// Drives points into the sliding window average block: a short directed run
// at the reset window length (extreme values, truncation, restarts during the
// fill), then random phases at window lengths from 0 to 127 with random
// sender gaps and receiver stalls. A separate checker predicts and compares
// the means; this module makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module sliding_window_average_xy_top_tb
   import swa_pkg::*;
;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   localparam int         CYCLE_LIMIT   = 600000;
   localparam int         SETTLE_CYCLES = 64;
   localparam sample_type SAMPLE_MAX    = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam sample_type SAMPLE_MIN    = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   mismatch_count;
   int   means_pending;
   bit   calm_sender   = 1'b0;
   bit   calm_receiver = 1'b0;

   swa_req_if req_ch ();
   swa_rsp_if rsp_ch ();
   swa_csr_if csr_ch ();

   sliding_window_average_xy_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   swa_mean_checker mean_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatch_count),
      .means_pending  (means_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sliding_window_average_xy_top regression: fail");
         $finish;
      end
   end

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 7))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return SAMPLE_MAX - $urandom_range(0, 3);
         3: return SAMPLE_MIN + $urandom_range(0, 3);
         4: return $urandom_range(0, 16) - 8;
         default: return $urandom();
      endcase
   endfunction

   task automatic send_point(sample_type xv, sample_type yv, logic fp);
      int gap;
      req_ch.valid       <= 1'b1;
      req_ch.x_value     <= xv;
      req_ch.y_value     <= yv;
      req_ch.first_point <= fp;
      do @(posedge clock); while (!req_ch.ready);
      gap = calm_sender ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the sender until every mean is back, then let the block go idle
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (means_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window_len(logic [LEN_WIDTH-1:0] len);
      csr_ch.valid      <= 1'b1;
      csr_ch.window_len <= len;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_phase(logic [LEN_WIDTH-1:0] len, int count, bit pause);
      int fp_pct;
      settle();
      write_window_len(len);
      calm_sender   <= ($urandom_range(0, 3) == 0);
      calm_receiver <= ($urandom_range(0, 3) == 0);
      fp_pct = (len >= 16) ? 1 : 4;
      for (int i = 0; i < count; i++) begin
         if (pause && i == count / 2) settle();
         send_point(pick_sample(), pick_sample(), $urandom_range(0, 99) < fp_pct);
      end
   endtask

   initial begin : receiver
      int stall;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = calm_receiver ? 0 : $urandom_range(0, 13);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            do @(posedge clock); while (!rsp_ch.valid);
            repeat (stall - 1) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.x_value     <= '0;
      req_ch.y_value     <= '0;
      req_ch.first_point <= 1'b0;
      csr_ch.valid       <= 1'b0;
      csr_ch.window_len  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset window length: extremes, truncation, restarts during the fill
      repeat (4) send_point(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
      repeat (4) send_point(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
      send_point(-1, 1, 1'b1);
      send_point(-2, 2, 1'b0);
      send_point(-1, 1, 1'b1);
      send_point(-1, 2, 1'b0);
      send_point(-1, 1, 1'b0);
      send_point(-2, 1, 1'b0);
      send_point(0, 0, 1'b0);
      send_point(SAMPLE_MAX, SAMPLE_MAX, 1'b0);

      run_phase(1, 80, 1'b0);
      run_phase(0, 60, 1'b0);
      run_phase(2, 80, 1'b1);
      run_phase(3, 70, 1'b0);
      run_phase(64, 200, 1'b0);
      run_phase(65, 100, 1'b0);
      run_phase(127, 150, 1'b0);
      run_phase(7, 90, 1'b0);
      run_phase(16, 100, 1'b0);
      run_phase(LEN_WIDTH'($urandom_range(1, 127)), 100, 1'b0);

      settle();
      if (mismatch_count == 0 && means_pending == 0) begin
         $display("sliding_window_average_xy_top regression: pass");
      end else begin
         $display("sliding_window_average_xy_top regression: fail");
      end
      $finish;
   end

endmodule
